### src/fsmm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fsmm_pkg;

  localparam int MAX_SLOTS = 64;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = 7;
  localparam int STAMP_W   = 64;
  localparam int DROP_W    = 32;
  localparam int STATUS_W  = 4;

  // Command codes
  localparam logic [1:0] CMD_PUBLISH = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_CONNECT = 2'd2;
  localparam logic [1:0] CMD_LOST    = 2'd3;

  // Sink status codes; anything else counts as an error
  localparam logic [1:0] SINK_OK   = 2'd0;
  localparam logic [1:0] SINK_FULL = 2'd1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_PUBLISHED = 4'd0;
  localparam logic [STATUS_W-1:0] ST_REFUSED   = 4'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SLOT   = 4'd2;
  localparam logic [STATUS_W-1:0] ST_SINK_FULL = 4'd3;
  localparam logic [STATUS_W-1:0] ST_SEND_ERR  = 4'd4;
  localparam logic [STATUS_W-1:0] ST_RELEASED  = 4'd5;
  localparam logic [STATUS_W-1:0] ST_BAD_MSG   = 4'd6;
  localparam logic [STATUS_W-1:0] ST_BAD_SLOT  = 4'd7;
  localparam logic [STATUS_W-1:0] ST_ATTACHED  = 4'd8;
  localparam logic [STATUS_W-1:0] ST_HS_FAIL   = 4'd9;
  localparam logic [STATUS_W-1:0] ST_DETACHED  = 4'd10;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = 4'd11;

  localparam logic [CNT_W-1:0] SLOTS_RESET = 7'd4;
  localparam logic [CNT_W-1:0] SLOTS_MIN   = 7'd2;
  localparam logic [CNT_W-1:0] SLOTS_MAX   = CNT_W'(MAX_SLOTS);

  // Saturate the programmed slot count into the usable range
  function automatic logic [CNT_W-1:0] slot_limit(input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] r;
    r = n;
    if (r > SLOTS_MAX) r = SLOTS_MAX;
    if (r < SLOTS_MIN) r = SLOTS_MIN;
    return r;
  endfunction

endpackage

`default_nettype wire

### src/fsmm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module fsmm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/frame_slot_mailbox_manager_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Payload
// -------   ------------------   --------------------------------------------------
// request   req_valid/req_ready  cmd, release_slot, message_ok, source_present,
//                                sink_status, frame_time
// result    res_valid/res_ready  status, chosen_slot, frame_number, frame_time_out,
//                                consumer_attached, dropped_frames
// config    cfg_we               cfg_data (slots_in_use), written at once, no wait
//
// A publish that may take a slot walks the stamp memory one entry per cycle through
// its single read port between capture and commit; every other request goes from
// capture straight to commit.
// One request is in flight at a time; the next is taken as soon as the current one
// has committed into the result register, even while that result still waits.
// A commit waits while the result register holds an untaken result.
// Reset clears the held mask, counters, link state and the per-slot valid bits; an
// entry that was never stamped reads as zero, so no clearing pass is needed.

module frame_slot_mailbox_manager_core
  import fsmm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // configuration
  input  wire logic                cfg_we,
  input  wire logic [CNT_W-1:0]    cfg_data,
  // request channel
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire logic [1:0]          cmd,
  input  wire logic [SLOT_W-1:0]   release_slot,
  input  wire logic                message_ok,
  input  wire logic                source_present,
  input  wire logic [1:0]          sink_status,
  input  wire logic [STAMP_W-1:0]  frame_time,
  // result channel
  output logic                     res_valid,
  input  wire logic                res_ready,
  output logic [STATUS_W-1:0]      status,
  output logic [SLOT_W-1:0]        chosen_slot,
  output logic [STAMP_W-1:0]       frame_number,
  output logic [STAMP_W-1:0]       frame_time_out,
  output logic                     consumer_attached,
  output logic [DROP_W-1:0]        dropped_frames
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC
  } state_t;

  state_t state;

  // Block state
  logic [CNT_W-1:0]     slots_in_use;
  logic                 attached;
  logic [MAX_SLOTS-1:0] held_mask;
  logic [MAX_SLOTS-1:0] slot_vld;
  logic [STAMP_W-1:0]   frame_counter;
  logic [DROP_W-1:0]    drop_counter;

  // Captured request
  logic [1:0]           r_cmd;
  logic [SLOT_W-1:0]    r_slot;
  logic                 r_msg_ok;
  logic                 r_src;
  logic [1:0]           r_sink;
  logic [STAMP_W-1:0]   r_time;
  logic [CNT_W-1:0]     limit;

  // Scan pipeline
  logic [CNT_W-1:0]     scan_addr;
  logic                 chk_valid;
  logic [SLOT_W-1:0]    chk_idx;
  logic [STAMP_W-1:0]   best_stamp;
  logic [SLOT_W-1:0]    best_idx;
  logic                 best_found;

  // Stamp memory
  logic                 ram_re;
  logic                 ram_we;
  logic [STAMP_W-1:0]   ram_rdata;
  logic [STAMP_W-1:0]   chk_stamp;
  logic                 scan_issue;

  // Commit values
  logic                 commit;
  logic [STATUS_W-1:0]  c_status;
  logic [SLOT_W-1:0]    c_slot;
  logic [STAMP_W-1:0]   c_num;
  logic [STAMP_W-1:0]   c_time;
  logic                 attached_next;
  logic [MAX_SLOTS-1:0] held_next;
  logic [STAMP_W-1:0]   frame_counter_next;
  logic [DROP_W-1:0]    drop_counter_next;
  logic [MAX_SLOTS-1:0] best_bit;
  logic [MAX_SLOTS-1:0] rel_bit;

  assign req_ready  = (state == S_IDLE);
  assign scan_issue = (state == S_SCAN) && (scan_addr < limit);
  assign ram_re     = scan_issue;
  assign commit     = (state == S_EXEC) && (!res_valid || res_ready);

  // Entries never stamped since reset read as zero
  assign chk_stamp = slot_vld[chk_idx] ? ram_rdata : '0;

  fsmm_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (MAX_SLOTS)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (best_idx),
    .wdata (frame_counter_next),
    .re    (ram_re),
    .raddr (scan_addr[SLOT_W-1:0]),
    .rdata (ram_rdata)
  );

  // Resolve the captured request against the current state
  always_comb begin
    best_bit           = MAX_SLOTS'(1) << best_idx;
    rel_bit            = MAX_SLOTS'(1) << r_slot;
    c_status           = ST_IGNORED;
    c_slot             = '0;
    c_num              = '0;
    c_time             = '0;
    attached_next      = attached;
    held_next          = held_mask;
    frame_counter_next = frame_counter + STAMP_W'(1);
    drop_counter_next  = drop_counter;
    ram_we             = 1'b0;

    unique case (r_cmd)
      CMD_PUBLISH: begin
        if (!attached || !r_src) begin
          c_status = ST_REFUSED;
        end else if (!best_found) begin
          drop_counter_next = drop_counter + DROP_W'(1);
          c_status          = ST_NO_SLOT;
        end else begin
          ram_we = commit;
          c_slot = best_idx;
          c_num  = frame_counter_next;
          c_time = r_time;
          if (r_sink == SINK_OK) begin
            held_next = held_mask | best_bit;
            c_status  = ST_PUBLISHED;
          end else if (r_sink == SINK_FULL) begin
            // slot is stamped but handed straight back
            drop_counter_next = drop_counter + DROP_W'(1);
            c_status          = ST_SINK_FULL;
          end else begin
            attached_next = 1'b0;
            held_next     = '0;
            c_status      = ST_SEND_ERR;
          end
        end
      end
      CMD_RELEASE: begin
        if (attached) begin
          if (!r_msg_ok) begin
            attached_next = 1'b0;
            held_next     = '0;
            c_status      = ST_BAD_MSG;
          end else if (CNT_W'(r_slot) >= limit) begin
            attached_next = 1'b0;
            held_next     = '0;
            c_status      = ST_BAD_SLOT;
            c_slot        = r_slot;
          end else begin
            held_next = held_mask & ~rel_bit;
            c_status  = ST_RELEASED;
            c_slot    = r_slot;
          end
        end
      end
      CMD_CONNECT: begin
        // drop any old consumer first
        held_next = '0;
        if (r_sink == SINK_OK) begin
          attached_next = 1'b1;
          c_status      = ST_ATTACHED;
        end else begin
          attached_next = 1'b0;
          c_status      = ST_HS_FAIL;
        end
      end
      CMD_LOST: begin
        if (attached) begin
          attached_next = 1'b0;
          held_next     = '0;
          c_status      = ST_DETACHED;
        end
      end
      default: begin
        c_status = ST_IGNORED;
      end
    endcase

    if (!(r_cmd == CMD_PUBLISH && ram_we)) begin
      frame_counter_next = frame_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      slots_in_use  <= SLOTS_RESET;
      attached      <= 1'b0;
      held_mask     <= '0;
      slot_vld      <= '0;
      frame_counter <= '0;
      drop_counter  <= '0;
      res_valid     <= 1'b0;
      chk_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        slots_in_use <= cfg_data;
      end

      // load a fresh result at commit, else drop the one just taken
      if (commit) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            // capture the request
            r_cmd      <= cmd;
            r_slot     <= release_slot;
            r_msg_ok   <= message_ok;
            r_src      <= source_present;
            r_sink     <= sink_status;
            r_time     <= frame_time;
            limit      <= slot_limit(slots_in_use);
            scan_addr  <= '0;
            chk_valid  <= 1'b0;
            best_stamp <= '1;
            best_idx   <= '0;
            best_found <= 1'b0;
            if (cmd == CMD_PUBLISH && attached && source_present) begin
              state <= S_SCAN;
            end else begin
              state <= S_EXEC;
            end
          end
        end
        S_SCAN: begin
          // advance the read address, check the entry read last cycle
          if (scan_issue) begin
            scan_addr <= scan_addr + CNT_W'(1);
            chk_idx   <= scan_addr[SLOT_W-1:0];
            chk_valid <= 1'b1;
          end else begin
            chk_valid <= 1'b0;
          end
          if (chk_valid && !held_mask[chk_idx] && (chk_stamp < best_stamp)) begin
            best_stamp <= chk_stamp;
            best_idx   <= chk_idx;
            best_found <= 1'b1;
          end
          if (!scan_issue && !chk_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          // hold until the result register is free
          if (commit) begin
            attached          <= attached_next;
            held_mask         <= held_next;
            frame_counter     <= frame_counter_next;
            drop_counter      <= drop_counter_next;
            if (ram_we) begin
              slot_vld <= slot_vld | best_bit;
            end
            status            <= c_status;
            chosen_slot       <= c_slot;
            frame_number      <= c_num;
            frame_time_out    <= c_time;
            consumer_attached <= attached_next;
            dropped_frames    <= drop_counter_next;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A detached block never keeps held slots
  a_held_needs_consumer: assert property (@(posedge clk) disable iff (rst)
    !attached |-> (held_mask == '0))
    else $error("held slots while detached");

  // Scan only looks at slots inside the active count
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    chk_valid |-> (CNT_W'(chk_idx) < limit))
    else $error("scan beyond slot count");

  // A published slot stays held while its result waits
  a_published_held: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status == ST_PUBLISHED) |-> held_mask[chosen_slot])
    else $error("published slot not held");

  // Drop counter moves by at most one per cycle
  a_drop_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (drop_counter == $past(drop_counter) ||
                     drop_counter == $past(drop_counter) + DROP_W'(1)))
    else $error("drop counter jumped");

  // Active slot count stays in its legal range while busy
  a_limit_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (limit >= SLOTS_MIN && limit <= SLOTS_MAX))
    else $error("slot count out of range");

endmodule

`default_nettype wire
